// File: sv/xmp_ir_packet_decoder_top_assert.svh
// Assertion macros for the IR packet decoder, included by xir_decoder.
// No dependencies; included by the modules that carry assertions.
`ifndef XMP_IR_PACKET_DECODER_TOP_ASSERT_SVH
`define XMP_IR_PACKET_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define XIR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xir assertion failed");

// Next-cycle implication, checked outside reset
`define XIR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xir assertion failed");

`endif

// File: sv/xir_pkg.sv
// Shared types and constants for the IR packet decoder.
// No dependencies; used by every module of the block.
package xir_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned REG_W   = 15;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned NIB_W   = 4;
    localparam int unsigned KEY_W   = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REGISTRY_A = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGISTRY_B = 8'd1;

    typedef enum logic [1:0] {
        ST_REGISTRY    = 2'd0,
        ST_DATA        = 2'd1,
        ST_CKSUM_ERR   = 2'd2,
        ST_NO_REGISTRY = 2'd3
    } status_t;

    // One decoded result beat
    typedef struct packed {
        status_t                status;
        logic [NIB_W-1:0]       owner;
        logic [NIB_W-1:0]       checksum_nibble;
        logic [NIB_W-1:0]       tag;
        logic [NIB_W-1:0]       peripheral_id;
        logic [REG_W-1:0]       registry_number;
        logic [KEY_W-1:0]       key_byte;
        logic                   repeat_flag;
        logic                   fmb_flag;
        logic                   ctrl_flag;
        logic                   shift_flag;
        logic                   alt_flag;
    } result_t;

    // Input stage handed to the decoder
    typedef struct packed {
        logic                   valid;
        logic [WORD_W-1:0]      word;
    } in_stage_t;

endpackage

// File: sv/xir_checksum.sv
// Nibble checksum check for one XMP packet word.
// Depends on xir_pkg.
module xir_checksum (
    input  logic [xir_pkg::WORD_W-1:0] word,
    output logic                       ok
);

    logic [3:0] s01, s23, s45, s67;
    logic [3:0] s0123, s4567, total;

    // Body sum (checksum nibble zeroed) plus received checksum must be 0 mod 16,
    // which is the sum of all eight raw nibbles wrapping to zero.
    always_comb
    begin
        s01   = word[3:0]   + word[7:4];
        s23   = word[11:8]  + word[15:12];
        s45   = word[19:16] + word[23:20];
        s67   = word[27:24] + word[31:28];
        s0123 = s01 + s23;
        s4567 = s45 + s67;
        total = s0123 + s4567;
    end

    assign ok = (total == 4'd0);

endmodule

// File: sv/xir_decoder.sv
// Packet classification, stored registry number and result register.
// Depends on xir_pkg, xir_checksum and the assertion macro header.
`include "xmp_ir_packet_decoder_top_assert.svh"

module xir_decoder (
    input  logic                      clk,
    input  logic                      rst_n,
    input  xir_pkg::in_stage_t        stage,
    input  logic [xir_pkg::REG_W-1:0] registry_a,
    input  logic [xir_pkg::REG_W-1:0] registry_b,
    output logic                      take,
    output logic                      out_valid,
    input  logic                      out_ready,
    output xir_pkg::result_t          result
);

    logic                      cksum_ok;
    logic                      load;
    logic [3:0]                ck;
    logic [xir_pkg::REG_W-1:0] low15;
    logic                      reg_hit;
    logic [xir_pkg::REG_W-1:0] stored_registry_reg;
    logic [xir_pkg::REG_W-1:0] stored_registry_next;
    logic                      out_valid_reg;
    xir_pkg::result_t          result_reg;
    xir_pkg::result_t          result_next;

    xir_checksum u_checksum (
        .word (stage.word),
        .ok   (cksum_ok)
    );

    // Result register frees up when empty or being drained
    assign take = !out_valid_reg || out_ready;
    assign load = stage.valid && take;

    assign ck      = stage.word[27:24];
    assign low15   = stage.word[xir_pkg::REG_W-1:0];
    assign reg_hit = (low15 == registry_a) || (low15 == registry_b);

    // Classify the packet and build the result beat
    always_comb
    begin
        result_next                 = '0;
        stored_registry_next        = stored_registry_reg;
        result_next.checksum_nibble = ck;
        if (!cksum_ok)
        begin
            result_next.status = xir_pkg::ST_CKSUM_ERR;
        end
        else if (reg_hit)
        begin
            stored_registry_next      = low15;
            result_next.status        = xir_pkg::ST_REGISTRY;
            result_next.owner         = stage.word[31:28];
            result_next.tag           = stage.word[23:20];
            result_next.peripheral_id = stage.word[19:16];
        end
        else if (stored_registry_reg != '0)
        begin
            result_next.status      = xir_pkg::ST_DATA;
            result_next.owner       = stage.word[31:28];
            result_next.tag         = stage.word[19:16];
            result_next.key_byte    = stage.word[15:8];
            result_next.repeat_flag = stage.word[23];
            result_next.fmb_flag    = stage.word[20];
            result_next.ctrl_flag   = stage.word[7];
            result_next.shift_flag  = stage.word[6];
            result_next.alt_flag    = stage.word[5];
        end
        else
        begin
            result_next.status = xir_pkg::ST_NO_REGISTRY;
        end
        result_next.registry_number = stored_registry_next;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg       <= 1'b0;
            stored_registry_reg <= '0;
        end
        else
        begin
            if (take)
            begin
                out_valid_reg <= stage.valid;
            end
            if (load)
            begin
                stored_registry_reg <= stored_registry_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // A bad checksum never touches the stored registry number
    `XIR_ASSERT_NEXT(a_cksum_keeps_reg, clk, rst_n, load && !cksum_ok, $stable(stored_registry_reg))
    // Reported registry number tracks the stored one after every load
    `XIR_ASSERT_NEXT(a_reg_reported, clk, rst_n, load, result_reg.registry_number == stored_registry_reg)
    // A data beat only goes out while a remote is registered
    `XIR_ASSERT_IMPL(a_data_needs_reg, clk, rst_n, out_valid_reg && result_reg.status == xir_pkg::ST_DATA, result_reg.registry_number != '0)

endmodule

// File: sv/xmp_ir_packet_decoder_top.sv
// Top level of the XMP IR packet decoder: input stage, config registers, decoder.
// Depends on xir_pkg, xir_checksum and xir_decoder.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------
//  in       | in_valid / in_ready    | packet_word
//  out      | out_valid / out_ready  | status, owner, ..., alt_flag
//  cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One packet per cycle while the output is not stalled; each packet passes two registers (input, result).
// The checksum adder tree and classification sit between those two registers.
// A stalled output holds its beat while the input register still takes one more.
// Reset clears valid bits, the stored registry number and both config registers.
// cfg_ready is always high; writes to indexes beyond the list are dropped.
module xmp_ir_packet_decoder_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [xir_pkg::WORD_W-1:0]    packet_word,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [xir_pkg::NIB_W-1:0]     owner,
    output logic [xir_pkg::NIB_W-1:0]     checksum_nibble,
    output logic [xir_pkg::NIB_W-1:0]     tag,
    output logic [xir_pkg::NIB_W-1:0]     peripheral_id,
    output logic [xir_pkg::REG_W-1:0]     registry_number,
    output logic [xir_pkg::KEY_W-1:0]     key_byte,
    output logic                          repeat_flag,
    output logic                          fmb_flag,
    output logic                          ctrl_flag,
    output logic                          shift_flag,
    output logic                          alt_flag,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [xir_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [xir_pkg::REG_W-1:0]     cfg_data
);

    logic                      in_valid_reg;
    logic [xir_pkg::WORD_W-1:0] word_reg;
    logic [xir_pkg::REG_W-1:0] registry_a_reg;
    logic [xir_pkg::REG_W-1:0] registry_b_reg;
    logic                      take;
    xir_pkg::in_stage_t        stage;
    xir_pkg::result_t          result;

    assign cfg_ready = 1'b1;
    assign in_ready  = !in_valid_reg || take;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            registry_a_reg <= '0;
            registry_b_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                xir_pkg::CFG_REGISTRY_A: registry_a_reg <= cfg_data;
                xir_pkg::CFG_REGISTRY_B: registry_b_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // Input stage payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= packet_word;
        end
    end

    assign stage.valid = in_valid_reg;
    assign stage.word  = word_reg;

    xir_decoder u_decoder (
        .clk        (clk),
        .rst_n      (rst_n),
        .stage      (stage),
        .registry_a (registry_a_reg),
        .registry_b (registry_b_reg),
        .take       (take),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result     (result)
    );

    // Unpack the result beat onto the ports
    assign status          = result.status;
    assign owner           = result.owner;
    assign checksum_nibble = result.checksum_nibble;
    assign tag             = result.tag;
    assign peripheral_id   = result.peripheral_id;
    assign registry_number = result.registry_number;
    assign key_byte        = result.key_byte;
    assign repeat_flag     = result.repeat_flag;
    assign fmb_flag        = result.fmb_flag;
    assign ctrl_flag       = result.ctrl_flag;
    assign shift_flag      = result.shift_flag;
    assign alt_flag        = result.alt_flag;

endmodule

// File: sim/xir_decoder_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the IR packet decoder: predicts every decoded beat and compares it.
// Depends on xir_pkg; instantiated beside the block by xmp_ir_packet_decoder_top_tb.
module xir_decoder_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [xir_pkg::WORD_W-1:0]    packet_word,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [1:0]                    status,
    input  logic [xir_pkg::NIB_W-1:0]     owner,
    input  logic [xir_pkg::NIB_W-1:0]     checksum_nibble,
    input  logic [xir_pkg::NIB_W-1:0]     tag,
    input  logic [xir_pkg::NIB_W-1:0]     peripheral_id,
    input  logic [xir_pkg::REG_W-1:0]     registry_number,
    input  logic [xir_pkg::KEY_W-1:0]     key_byte,
    input  logic                          repeat_flag,
    input  logic                          fmb_flag,
    input  logic                          ctrl_flag,
    input  logic                          shift_flag,
    input  logic                          alt_flag,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [xir_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [xir_pkg::REG_W-1:0]     cfg_data,
    output int                            fail_count,
    output int                            pending
);

    xir_pkg::result_t          decoded_q[$];
    logic [xir_pkg::REG_W-1:0] registry_a;
    logic [xir_pkg::REG_W-1:0] registry_b;
    logic [xir_pkg::REG_W-1:0] held_registry;
    int                        errors = 0;

    assign fail_count = errors;

    // Decode one packet word against the registry numbers and the held registration
    function automatic xir_pkg::result_t decode_packet(
        input logic [xir_pkg::WORD_W-1:0] w,
        input logic [xir_pkg::REG_W-1:0]  num_a,
        input logic [xir_pkg::REG_W-1:0]  num_b,
        input logic [xir_pkg::REG_W-1:0]  held);
        xir_pkg::result_t          r;
        logic [xir_pkg::NIB_W-1:0] seal;
        r    = '0;
        seal = '0;
        // nibble sum of the word with the checksum nibble left out, negated mod 16
        for (int i = 0; i < 8; i++)
        begin
            if (i != 6)
                seal = seal - w[4*i +: 4];
        end
        r.checksum_nibble = w[27:24];
        r.registry_number = held;
        if (seal != w[27:24])
        begin
            r.status = xir_pkg::ST_CKSUM_ERR;
        end
        else if (w[14:0] == num_a || w[14:0] == num_b)
        begin
            r.status          = xir_pkg::ST_REGISTRY;
            r.owner           = w[31:28];
            r.tag             = w[23:20];
            r.peripheral_id   = w[19:16];
            r.registry_number = w[14:0];
        end
        else if (held != '0)
        begin
            r.status      = xir_pkg::ST_DATA;
            r.owner       = w[31:28];
            r.tag         = w[19:16];
            r.key_byte    = w[15:8];
            r.repeat_flag = w[23];
            r.fmb_flag    = w[20];
            r.ctrl_flag   = w[7];
            r.shift_flag  = w[6];
            r.alt_flag    = w[5];
        end
        else
        begin
            r.status = xir_pkg::ST_NO_REGISTRY;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    // Track config and registration, queue predictions, compare result beats
    always @(posedge clk or negedge rst_n)
    begin
        xir_pkg::result_t want;
        if (!rst_n)
        begin
            registry_a    <= '0;
            registry_b    <= '0;
            held_registry <= '0;
            decoded_q.delete();
            pending       <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == xir_pkg::CFG_REGISTRY_A)
                    registry_a <= cfg_data;
                else if (cfg_index == xir_pkg::CFG_REGISTRY_B)
                    registry_b <= cfg_data;
            end
            if (in_valid && in_ready)
            begin
                want = decode_packet(packet_word, registry_a, registry_b, held_registry);
                held_registry <= want.registry_number;
                decoded_q.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    $error("result beat with no packet outstanding");
                    errors++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("owner", 32'(want.owner), 32'(owner));
                    check_field("checksum_nibble", 32'(want.checksum_nibble),
                                32'(checksum_nibble));
                    check_field("tag", 32'(want.tag), 32'(tag));
                    check_field("peripheral_id", 32'(want.peripheral_id), 32'(peripheral_id));
                    check_field("registry_number", 32'(want.registry_number),
                                32'(registry_number));
                    check_field("key_byte", 32'(want.key_byte), 32'(key_byte));
                    check_field("repeat_flag", 32'(want.repeat_flag), 32'(repeat_flag));
                    check_field("fmb_flag", 32'(want.fmb_flag), 32'(fmb_flag));
                    check_field("ctrl_flag", 32'(want.ctrl_flag), 32'(ctrl_flag));
                    check_field("shift_flag", 32'(want.shift_flag), 32'(shift_flag));
                    check_field("alt_flag", 32'(want.alt_flag), 32'(alt_flag));
                end
            end
            pending <= decoded_q.size();
        end
    end

endmodule

// File: sim/xmp_ir_packet_decoder_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the IR packet decoder: clock, reset, packet and config stimulus, verdict.
// Depends on xir_pkg, xmp_ir_packet_decoder_top and xir_decoder_checker.
module xmp_ir_packet_decoder_top_tb;

    localparam int RESET_CYCLES    = 12;
    localparam int PHASE_COUNT     = 8;
    localparam int PHASE_PACKETS   = 166;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int DRAIN_TAIL      = 4;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam logic [xir_pkg::CFG_IDX_W-1:0] CFG_FIRST_UNUSED =
        xir_pkg::CFG_REGISTRY_B + 1'b1;
    localparam logic [xir_pkg::CFG_IDX_W-1:0] CFG_LAST_UNUSED  = '1;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic [xir_pkg::WORD_W-1:0]    packet_word;
    logic                          out_valid;
    logic                          out_ready;
    logic [1:0]                    status;
    logic [xir_pkg::NIB_W-1:0]     owner;
    logic [xir_pkg::NIB_W-1:0]     checksum_nibble;
    logic [xir_pkg::NIB_W-1:0]     tag;
    logic [xir_pkg::NIB_W-1:0]     peripheral_id;
    logic [xir_pkg::REG_W-1:0]     registry_number;
    logic [xir_pkg::KEY_W-1:0]     key_byte;
    logic                          repeat_flag;
    logic                          fmb_flag;
    logic                          ctrl_flag;
    logic                          shift_flag;
    logic                          alt_flag;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [xir_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [xir_pkg::REG_W-1:0]     cfg_data;
    int                            fail_count;
    int                            pending;

    // Stimulus-side view of the registry numbers, used to aim registry packets
    logic [xir_pkg::REG_W-1:0]     aim_a = '0;
    logic [xir_pkg::REG_W-1:0]     aim_b = '0;
    int                            send_idle_pct  = 0;
    int                            recv_stall_pct = 0;
    logic                          hold_off_req   = 1'b0;
    int                            stuck_cycles   = 0;

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    xmp_ir_packet_decoder_top u_top (.*);

    xir_decoder_checker u_checker (.*);

    // Fill in a valid checksum nibble
    function automatic logic [xir_pkg::WORD_W-1:0] seal_packet(
        input logic [xir_pkg::WORD_W-1:0] raw);
        logic [xir_pkg::NIB_W-1:0] seal;
        seal = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (i != 6)
                seal = seal - raw[4*i +: 4];
        end
        return {raw[31:28], seal, raw[23:0]};
    endfunction

    // Mostly well-formed data and registry packets, some corrupted, some raw noise
    function automatic logic [xir_pkg::WORD_W-1:0] random_packet();
        logic [xir_pkg::WORD_W-1:0] w;
        int unsigned                roll;
        w    = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            w[14:0] = $urandom_range(0, 1) ? aim_a : aim_b;
        if (roll < 70)
            return seal_packet(w);
        if (roll < 85)
            return seal_packet(w)
                ^ {4'h0, xir_pkg::NIB_W'($urandom_range(1, 15)), 24'h0};
        return w;
    endfunction

    // Offer one packet beat; called and returns at a falling edge
    task automatic send_packet(input logic [xir_pkg::WORD_W-1:0] w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        packet_word <= w;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // One config beat; caller lowers cfg_valid after the last one
    task automatic write_register(input logic [xir_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [xir_pkg::REG_W-1:0]     data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        if (idx == xir_pkg::CFG_REGISTRY_A)
            aim_a = data;
        else if (idx == xir_pkg::CFG_REGISTRY_B)
            aim_b = data;
    endtask

    // Stop offering and wait until every predicted beat has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_TAIL) @(negedge clk);
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: cycles with no beat on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin
        logic [xir_pkg::REG_W-1:0] shared_num;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        packet_word = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Both registry numbers zero after reset: nothing registered yet
        send_packet(seal_packet(32'hA0B5_C3E1));
        send_packet(seal_packet(32'hA0B5_C3E1) ^ 32'h0100_0000);
        // zero registry number matches, registers zero, block stays unregistered
        send_packet(seal_packet(32'h5063_0000));
        send_packet(seal_packet(32'h30FF_FFFF));

        drain_results();
        write_register(xir_pkg::CFG_REGISTRY_A, 15'h7FFF);
        write_register(xir_pkg::CFG_REGISTRY_B, 15'h1234);
        // unused indexes must be dropped
        write_register(CFG_LAST_UNUSED, 15'h7FFF);
        write_register(CFG_FIRST_UNUSED, 15'h1234);
        cfg_valid <= 1'b0;

        // Field extremes, each flag alone, both registry numbers
        send_packet(seal_packet(32'hF0FF_FFFF));
        send_packet(seal_packet(32'hF0FF_FFFE));
        send_packet(seal_packet(32'h0000_0000));
        send_packet(seal_packet(32'h7095_1234));
        send_packet(32'hFFFF_FFFF);
        send_packet(seal_packet(32'h0080_0000));
        send_packet(seal_packet(32'h0010_0000));
        send_packet(seal_packet(32'h0000_0080));
        send_packet(seal_packet(32'h0000_0040));
        send_packet(seal_packet(32'h0000_0020));
        send_packet(seal_packet(32'h000C_AB00));
        send_packet(seal_packet(32'h8000_1234) ^ 32'h0F00_0000);

        // Random phases over several register settings and idling modes
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            drain_results();
            shared_num = xir_pkg::REG_W'($urandom_range(0, 32767));
            case (p)
                0:
                begin
                    write_register(xir_pkg::CFG_REGISTRY_A, 15'h7FFF);
                    write_register(xir_pkg::CFG_REGISTRY_B, 15'h0000);
                end
                1:
                begin
                    write_register(xir_pkg::CFG_REGISTRY_A, 15'h0001);
                    write_register(xir_pkg::CFG_REGISTRY_B, 15'h7FFF);
                end
                3:
                begin
                    write_register(xir_pkg::CFG_REGISTRY_A, shared_num);
                    write_register(xir_pkg::CFG_REGISTRY_B, shared_num);
                end
                4:
                begin
                    write_register(xir_pkg::CFG_REGISTRY_A, 15'h5555);
                    write_register(xir_pkg::CFG_REGISTRY_B, 15'h2AAA);
                end
                5:
                begin
                    write_register(xir_pkg::CFG_REGISTRY_A, shared_num);
                    write_register(xir_pkg::CFG_REGISTRY_B, 15'h0000);
                end
                default:
                begin
                    write_register(xir_pkg::CFG_REGISTRY_A,
                                   xir_pkg::REG_W'($urandom_range(0, 32767)));
                    write_register(xir_pkg::CFG_REGISTRY_B,
                                   xir_pkg::REG_W'($urandom_range(0, 32767)));
                end
            endcase
            if (p % 2 == 1)
                write_register(
                    xir_pkg::CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_UNUSED)),
                    xir_pkg::REG_W'($urandom_range(0, 32767)));
            cfg_valid <= 1'b0;

            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 68;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 68;
                end
                default:
                begin
                    send_idle_pct  = 26;
                    recv_stall_pct = 26;
                end
            endcase
            // back-pressure: sender keeps offering while the receiver holds off
            if (p == 0)
                hold_off_req = 1'b1;

            for (int n = 0; n < PHASE_PACKETS; n++)
                send_packet(random_packet());
        end

        drain_results();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/xir_pkg.sv
sv/xir_checksum.sv
sv/xir_decoder.sv
sv/xmp_ir_packet_decoder_top.sv
sim/xir_decoder_checker.sv
sim/xmp_ir_packet_decoder_top_tb.sv
